>>> hw/rtl/sync_header_frame_drive_mixer_assert.svh
// assertion macros for the sync header deframer
// used by sync_header_frame_drive_mixer, which supplies i_clk and i_rst_n
`ifndef SYNC_HEADER_FRAME_DRIVE_MIXER_ASSERT_SVH
`define SYNC_HEADER_FRAME_DRIVE_MIXER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SHFDM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, quiet during reset
`define SHFDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

>>> hw/rtl/shfdm_pkg.sv
// shared types and constants for the sync header deframer
// no dependencies
package shfdm_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'hAA;
    localparam logic [7:0] SYNC_SECOND  = 8'h55;
    localparam int         FRAME_BYTES  = 16;
    localparam int         STORE_DEPTH  = FRAME_BYTES - 1;
    localparam int         COUNT_W      = $clog2(FRAME_BYTES);
    localparam int         WORDS        = FRAME_BYTES / 2;
    localparam logic signed [17:0] STICK_CENTRE = 18'sd512;

    typedef logic [7:0]          t_byte;
    typedef logic signed [15:0]  t_word;
    typedef logic signed [16:0]  t_drive;
    typedef logic [2:0]          t_mode;
    typedef logic [COUNT_W-1:0]  t_count;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_SYNC = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

endpackage

>>> hw/rtl/sync_header_frame_drive_mixer.sv
// sync header deframer with joystick drive mixing, top level
// depends on shfdm_pkg and sync_header_frame_drive_mixer_assert.svh
//
// usage
// bytes enter on the rx channel (i_rx_valid / o_rx_ready / i_rx_byte), one
// request per cycle unless a frame end waits on a pending result. the block hunts for
// 0xAA then 0x55, then captures 16 payload bytes as eight little-endian signed words.
// the sixteenth byte makes one request on the result channel (o_res_valid /
// i_res_ready): pot words, left and right drive, buzzer flag and mode.
// result path: the last payload byte loads the input register on acceptance, and the
// result register loads from it once any waiting result has been taken.
// throughput: one byte per cycle, set by the single-pass parse stage, but see stall.
// stall: when a result waits, only a byte that completes a further frame is
// held in the input register; all other bytes keep flowing.
// reset: synchronous, active low; clears both valid flags, the parse phase
// and the byte count. the payload store is not cleared; each entry is
// written within a frame before it is read.
module sync_header_frame_drive_mixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  shfdm_pkg::t_byte   i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output shfdm_pkg::t_word   o_pot_one,
    output shfdm_pkg::t_word   o_pot_two,
    output shfdm_pkg::t_drive  o_drive_left,
    output shfdm_pkg::t_drive  o_drive_right,
    output logic               o_buzzer_on,
    output shfdm_pkg::t_mode   o_car_mode
);
    import shfdm_pkg::*;
    `include "sync_header_frame_drive_mixer_assert.svh"

    localparam t_count LAST_COUNT = COUNT_W'(STORE_DEPTH);

    logic   r_in_vld, n_in_vld;
    t_byte  r_in_byte;
    t_phase r_phase, n_phase;
    t_count r_count, n_count;
    t_byte  r_store [STORE_DEPTH];
    logic   store_we;

    logic   r_out_vld, n_out_vld;
    t_word  r_pot_one, r_pot_two;
    t_drive r_left, r_right;
    logic   r_buzzer;
    t_mode  r_mode;

    logic   emit, go, in_ready;
    t_word  w [WORDS];
    logic signed [17:0] x, y;
    logic signed [18:0] d_a, d_b, h_a, h_b;

    assign emit     = r_in_vld && (r_phase == PH_DATA) && (r_count == LAST_COUNT);
    assign go       = r_in_vld && (!emit || !r_out_vld || i_res_ready);
    assign in_ready = !r_in_vld || go;
    assign n_in_vld = (i_rx_valid && in_ready) || (r_in_vld && !go);

    // parse phase
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        store_we = 1'b0;
        if (go) begin
            case (r_phase)
                PH_SYNC: begin
                    if (r_in_byte == SYNC_SECOND) begin
                        n_phase = PH_DATA;
                        n_count = '0;
                    end else if (r_in_byte == SYNC_FIRST) begin
                        n_phase = PH_SYNC;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (r_count != LAST_COUNT) begin
                        store_we = 1'b1;
                        n_count  = r_count + 1'b1;
                    end else begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                    end
                end
                default: begin
                    n_phase = (r_in_byte == SYNC_FIRST) ? PH_SYNC : PH_HUNT;
                end
            endcase
        end
    end

    // word assembly and drive mixing
    always_comb begin
        for (int k = 0; k < WORDS - 1; k++) begin
            w[k] = {r_store[2*k+1], r_store[2*k]};
        end
        w[WORDS-1] = {r_in_byte, r_store[STORE_DEPTH-1]};
    end

    assign x   = 18'(w[2]) - STICK_CENTRE;
    assign y   = 18'(w[3]) - STICK_CENTRE;
    assign d_a = 19'(x) - 19'(y);
    assign d_b = -19'(y) - 19'(x);
    // halve, truncating toward zero
    assign h_a = (d_a + 19'(d_a[18])) >>> 1;
    assign h_b = (d_b + 19'(d_b[18])) >>> 1;

    assign n_out_vld = (go && emit) ? 1'b1 : (i_res_ready ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && in_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (store_we) begin
            r_store[r_count] <= r_in_byte;
        end
        if (go && emit) begin
            r_pot_one <= w[0];
            r_pot_two <= w[1];
            r_left    <= y[17] ? h_a[16:0] : h_b[16:0];
            r_right   <= y[17] ? h_b[16:0] : h_a[16:0];
            r_buzzer  <= (w[4] == 16'sd0);
            r_mode    <= {w[5] == 16'sd1, w[6] == 16'sd1, w[7] == 16'sd1};
        end
    end

    assign o_rx_ready    = in_ready;
    assign o_res_valid   = r_out_vld;
    assign o_pot_one     = r_pot_one;
    assign o_pot_two     = r_pot_two;
    assign o_drive_left  = r_left;
    assign o_drive_right = r_right;
    assign o_buzzer_on   = r_buzzer;
    assign o_car_mode    = r_mode;

    `SHFDM_ASSERT_NOW(a_count_only_in_data, r_phase != PH_DATA, r_count == '0)
    `SHFDM_ASSERT_NEXT(a_emit_loads_result, go && emit, r_out_vld)
    `SHFDM_ASSERT_NOW(a_stall_only_when_blocked, r_in_vld && !go,
        emit && r_out_vld && !i_res_ready)
    `SHFDM_ASSERT_NEXT(a_held_byte_kept, r_in_vld && !go,
        r_in_vld && $stable(r_in_byte))

endmodule
